// ===== hw/rtl/hmed_pkg.sv =====
// Package for the HTTP message end detector.
// Holds payload and queue item types, character codes, phase and rule codes.
// Used by every module under hw/rtl; depends on nothing.
package hmed_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int KEY_LEN = 16;
  localparam int KEY_IDX_BITS = $clog2(KEY_LEN);
  localparam int QUEUE_DEPTH = 2;
  localparam int HISTORY_LEN = 8;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_LO_H  = 8'h68;
  localparam logic [7:0] CHAR_LO_T  = 8'h74;
  localparam logic [7:0] CHAR_LO_M  = 8'h6D;
  localparam logic [7:0] CHAR_LO_L  = 8'h6C;
  localparam logic [7:0] CHAR_UP_H  = 8'h48;
  localparam logic [7:0] CHAR_UP_T  = 8'h54;
  localparam logic [7:0] CHAR_UP_M  = 8'h4D;
  localparam logic [7:0] CHAR_UP_L  = 8'h4C;

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_VALUE  = 2'd1;
  localparam logic [1:0] PH_VALID  = 2'd2;
  localparam logic [1:0] PH_ERROR  = 2'd3;

  localparam logic [2:0] RULE_NONE   = 3'd0;
  localparam logic [2:0] RULE_LENGTH = 3'd1;
  localparam logic [2:0] RULE_BLANK  = 3'd2;
  localparam logic [2:0] RULE_LOWER  = 3'd3;
  localparam logic [2:0] RULE_UPPER  = 3'd4;

  localparam logic [3:0] SEEN_MAX = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
  } in_t;

  typedef struct packed {
    logic       complete;
    logic [2:0] end_rule;
    logic       length_error;
    logic       header_done;
  } out_t;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               message_start;
    logic               is_cr;
    logic               is_lf;
    logic               is_digit;
    logic               is_blank;
    logic [3:0]         digit;
    logic [KEY_LEN-1:0] key_hit;
  } class_t;

  function automatic logic [7:0] key_char(input logic [KEY_IDX_BITS-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:  ch = 8'h43;
      4'd1:  ch = 8'h6F;
      4'd2:  ch = 8'h6E;
      4'd3:  ch = 8'h74;
      4'd4:  ch = 8'h65;
      4'd5:  ch = 8'h6E;
      4'd6:  ch = 8'h74;
      4'd7:  ch = 8'h2D;
      4'd8:  ch = 8'h4C;
      4'd9:  ch = 8'h65;
      4'd10: ch = 8'h6E;
      4'd11: ch = 8'h67;
      4'd12: ch = 8'h74;
      4'd13: ch = 8'h68;
      4'd14: ch = 8'h3A;
      default: ch = 8'h20;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/hmed_front.sv =====
// Front classifier of the HTTP message end detector.
// Turns one request byte into a queue item with character class flags.
// Depends on hmed_pkg.
module hmed_front (
  input  hmed_pkg::in_t    item,
  output hmed_pkg::class_t cls
);

  always_comb begin
    cls.data_byte     = item.data_byte;
    cls.message_start = item.message_start;
    cls.is_cr         = item.data_byte == hmed_pkg::CHAR_CR;
    cls.is_lf         = item.data_byte == hmed_pkg::CHAR_LF;
    cls.is_digit      = (item.data_byte >= hmed_pkg::CHAR_ZERO) &&
                        (item.data_byte <= hmed_pkg::CHAR_NINE);
    cls.is_blank      = (item.data_byte == hmed_pkg::CHAR_SPACE) ||
                        (item.data_byte == hmed_pkg::CHAR_TAB);
    cls.digit         = 4'(item.data_byte - hmed_pkg::CHAR_ZERO);
    for (int i = 0; i < hmed_pkg::KEY_LEN; i++) begin
      cls.key_hit[i] = item.data_byte ==
                       hmed_pkg::key_char(hmed_pkg::KEY_IDX_BITS'(i));
    end
  end

endmodule

// ===== hw/rtl/hmed_queue.sv =====
// Short queue between front and back of the HTTP message end detector.
// Holds classified request bytes so each side can stall on its own.
// Depends on hmed_pkg.
module hmed_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hmed_pkg::class_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output hmed_pkg::class_t head_item
);

  localparam int DEPTH = hmed_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  hmed_pkg::class_t slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic do_push;
  logic do_pop;

  assign full       = count == CNT_BITS'(DEPTH);
  assign head_valid = count != '0;
  assign head_item  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/hmed_back.sv =====
// Back end of the HTTP message end detector.
// Tracks length line, blank line, body count and tails; drives the result register.
// Depends on hmed_pkg.
module hmed_back #(
  parameter int LENGTH_BITS = hmed_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  hmed_pkg::class_t head_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output hmed_pkg::out_t   out_item
);

  localparam int LB = LENGTH_BITS;
  localparam logic [LB-1:0] MAXV = '1;

  logic [3:0]                  bytes_seen, bytes_seen_next;
  logic [7:0]                  recent [hmed_pkg::HISTORY_LEN];
  logic [7:0]                  recent_cur [hmed_pkg::HISTORY_LEN];
  logic [hmed_pkg::KEY_IDX_BITS:0] key_prog, key_prog_next;
  logic [1:0]                  phase, phase_next;
  logic [LB-1:0]               length_value, length_value_next;
  logic                        digit_seen, digit_seen_next;
  logic                        digit_closed, digit_closed_next;
  logic [2:0]                  blank_prog, blank_prog_next;
  logic [LB-1:0]               body_bytes, body_bytes_next;
  hmed_pkg::out_t              result;

  logic                        start;
  logic [3:0]                  seen_c;
  logic [hmed_pkg::KEY_IDX_BITS:0] kp;
  logic [1:0]                  phase_c;
  logic [LB-1:0]               value_c;
  logic                        dseen_c;
  logic                        dclosed_c;
  logic [2:0]                  bp;
  logic [LB-1:0]               body_c;
  logic [LB+3:0]               acc;
  logic [7:0]                  c;
  logic                        tail_blank, tail_lower, tail_upper;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    start     = head_item.message_start;
    c         = head_item.data_byte;
    seen_c    = start ? '0 : bytes_seen;
    kp        = start ? '0 : key_prog;
    phase_c   = start ? hmed_pkg::PH_SEARCH : phase;
    value_c   = start ? '0 : length_value;
    dseen_c   = start ? 1'b0 : digit_seen;
    dclosed_c = start ? 1'b0 : digit_closed;
    bp        = start ? '0 : blank_prog;
    body_c    = start ? '0 : body_bytes;
    for (int i = 0; i < hmed_pkg::HISTORY_LEN; i++) begin
      recent_cur[i] = start ? 8'h00 : recent[i];
    end

    bytes_seen_next = (seen_c < hmed_pkg::SEEN_MAX) ? seen_c + 1'b1 : seen_c;

    body_bytes_next = body_c;
    blank_prog_next = bp;
    if (bp >= 3'd4) begin
      if (body_c != MAXV) begin
        body_bytes_next = body_c + 1'b1;
      end
    end else begin
      if (bp[0] == 1'b0 ? head_item.is_cr : head_item.is_lf) begin
        blank_prog_next = bp + 1'b1;
      end else begin
        blank_prog_next = head_item.is_cr ? 3'd1 : 3'd0;
      end
    end

    key_prog_next     = kp;
    phase_next        = phase_c;
    length_value_next = value_c;
    digit_seen_next   = dseen_c;
    digit_closed_next = dclosed_c;
    acc = ({4'b0, value_c} << 3) + ({4'b0, value_c} << 1) +
          (LB + 4)'(head_item.digit);
    unique case (phase_c)
      hmed_pkg::PH_SEARCH: begin
        if (kp[hmed_pkg::KEY_IDX_BITS]) begin
          kp = '0;
        end
        if (head_item.key_hit[kp[hmed_pkg::KEY_IDX_BITS-1:0]]) begin
          key_prog_next = kp + 1'b1;
        end else begin
          key_prog_next = head_item.key_hit[0] ? (hmed_pkg::KEY_IDX_BITS + 1)'(1) : '0;
        end
        if (key_prog_next == (hmed_pkg::KEY_IDX_BITS + 1)'(hmed_pkg::KEY_LEN)) begin
          phase_next        = hmed_pkg::PH_VALUE;
          length_value_next = '0;
          digit_seen_next   = 1'b0;
          digit_closed_next = 1'b0;
        end
      end
      hmed_pkg::PH_VALUE: begin
        if (recent_cur[0] == hmed_pkg::CHAR_CR && head_item.is_lf) begin
          phase_next = dseen_c ? hmed_pkg::PH_VALID : hmed_pkg::PH_ERROR;
        end else if (!dclosed_c) begin
          priority if (head_item.is_digit) begin
            length_value_next = (acc[LB+3:LB] != 4'd0) ? MAXV : acc[LB-1:0];
            digit_seen_next   = 1'b1;
          end else if (!dseen_c && head_item.is_blank) begin
            digit_closed_next = 1'b0;
          end else begin
            digit_closed_next = 1'b1;
          end
        end
      end
      default: begin
        phase_next = phase_c;
      end
    endcase

    tail_blank = head_item.is_lf && recent_cur[0] == hmed_pkg::CHAR_CR &&
                 recent_cur[1] == hmed_pkg::CHAR_LF && recent_cur[2] == hmed_pkg::CHAR_CR;
    tail_lower = c == hmed_pkg::CHAR_GT && recent_cur[0] == hmed_pkg::CHAR_LO_L &&
                 recent_cur[1] == hmed_pkg::CHAR_LO_M && recent_cur[2] == hmed_pkg::CHAR_LO_T &&
                 recent_cur[3] == hmed_pkg::CHAR_LO_H && recent_cur[4] == hmed_pkg::CHAR_SLASH &&
                 recent_cur[5] == hmed_pkg::CHAR_LT;
    tail_upper = head_item.is_lf && recent_cur[0] == hmed_pkg::CHAR_CR &&
                 recent_cur[1] == hmed_pkg::CHAR_GT && recent_cur[2] == hmed_pkg::CHAR_UP_L &&
                 recent_cur[3] == hmed_pkg::CHAR_UP_M && recent_cur[4] == hmed_pkg::CHAR_UP_T &&
                 recent_cur[5] == hmed_pkg::CHAR_UP_H && recent_cur[6] == hmed_pkg::CHAR_SLASH &&
                 recent_cur[7] == hmed_pkg::CHAR_LT;

    priority if (phase_next == hmed_pkg::PH_VALID && blank_prog_next >= 3'd4 &&
                 body_bytes_next >= length_value_next) begin
      result.end_rule = hmed_pkg::RULE_LENGTH;
    end else if (bytes_seen_next > 4'd4 && tail_blank) begin
      result.end_rule = hmed_pkg::RULE_BLANK;
    end else if (bytes_seen_next > 4'd7 && tail_lower) begin
      result.end_rule = hmed_pkg::RULE_LOWER;
    end else if (bytes_seen_next > 4'd9 && tail_upper) begin
      result.end_rule = hmed_pkg::RULE_UPPER;
    end else begin
      result.end_rule = hmed_pkg::RULE_NONE;
    end
    result.complete     = result.end_rule != hmed_pkg::RULE_NONE;
    result.length_error = phase_next == hmed_pkg::PH_ERROR;
    result.header_done  = blank_prog_next >= 3'd4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen   <= '0;
      key_prog     <= '0;
      phase        <= hmed_pkg::PH_SEARCH;
      length_value <= '0;
      digit_seen   <= 1'b0;
      digit_closed <= 1'b0;
      blank_prog   <= '0;
      body_bytes   <= '0;
      for (int i = 0; i < hmed_pkg::HISTORY_LEN; i++) begin
        recent[i] <= 8'h00;
      end
    end else if (pop) begin
      bytes_seen   <= bytes_seen_next;
      key_prog     <= key_prog_next;
      phase        <= phase_next;
      length_value <= length_value_next;
      digit_seen   <= digit_seen_next;
      digit_closed <= digit_closed_next;
      blank_prog   <= blank_prog_next;
      body_bytes   <= body_bytes_next;
      recent[0]    <= c;
      for (int i = 1; i < hmed_pkg::HISTORY_LEN; i++) begin
        recent[i] <= recent_cur[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= result;
    end
  end

endmodule

// ===== hw/rtl/http_message_end_detector_core.sv =====
// Top level of the HTTP message end detector.
// Wires the front classifier, the classified-byte queue and the back end.
// Depends on hmed_pkg, hmed_front, hmed_queue and hmed_back.
//
// Usage:
//   Input channel in_valid/in_ready/in_item carries one message byte per
//   request; set message_start on the first byte of each message to clear
//   all tracking before that byte is taken.
//   Output channel out_valid/out_ready/out_item carries one result per byte:
//   complete, end_rule, length_error and header_done for the message so far.
//   An accepted byte is registered in the queue and, when the output register
//   is free, its result is registered in the output register.
//   Throughput: one byte per cycle unless a result waits with out_ready low;
//   each byte updates key matcher, decimal accumulate, body counter, tails.
//   Reset clears the queue, the output valid flag and all message tracking.
//   A stalled receiver holds the result register; the two-entry queue keeps
//   taking bytes until full, then in_ready drops until the receiver drains.
module http_message_end_detector_core #(
  parameter int LENGTH_BITS = hmed_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hmed_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output hmed_pkg::out_t out_item
);

  hmed_pkg::class_t cls;
  hmed_pkg::class_t head_item;
  logic             full;
  logic             head_valid;
  logic             pop;

  assign in_ready = !full;

  hmed_front u_front (
    .item (in_item),
    .cls  (cls)
  );

  hmed_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid),
    .push_item  (cls),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  hmed_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

// ===== dv/message_end_check.sv =====
`timescale 1ns / 1ps
// Result checker for http_message_end_detector_core: predicts the end flags
// for each accepted request byte and compares them with the output channel.
// Depends on hmed_pkg.
module message_end_check (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  hmed_pkg::in_t  in_item,
  input  logic           out_valid,
  input  logic           out_ready,
  input  hmed_pkg::out_t out_item,
  output int             mismatches,
  output int             pending
);
  import hmed_pkg::*;

  localparam logic [127:0] KEY_TEXT   = "Content-Length: ";
  localparam logic [71:0]  BLANK_TAIL = {40'h0, CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};
  localparam logic [71:0]  LOWER_TAIL = {16'h0, "</html>"};
  localparam logic [71:0]  UPPER_TAIL = {"</HTML>", CHAR_CR, CHAR_LF};
  localparam logic [63:0]  LEN_MAX    = 64'hFFFF_FFFF;

  logic [3:0]  msg_bytes;
  logic [7:0]  history [8];
  logic [4:0]  key_pos;
  logic [1:0]  len_phase;
  logic [63:0] len_value;
  logic        digit_seen;
  logic        digits_closed;
  logic [2:0]  blank_pos;
  logic [63:0] body_count;
  out_t        expected_ends [$];
  int          fail_count;

  function automatic void clear_tracking();
    msg_bytes     = '0;
    foreach (history[i]) history[i] = '0;
    key_pos       = '0;
    len_phase     = PH_SEARCH;
    len_value     = '0;
    digit_seen    = 1'b0;
    digits_closed = 1'b0;
    blank_pos     = '0;
    body_count    = '0;
  endfunction

  function automatic logic tail_match(input logic [71:0] pat, input int n,
                                      input logic [7:0] c);
    logic hit;
    hit = (pat[7:0] == c);
    for (int k = 1; k < n; k++) begin
      if (pat[8*k +: 8] != history[k-1]) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic out_t next_end_result(input logic [7:0] c, input logic start);
    logic [2:0]  rule;
    logic [4:0]  kp;
    logic [63:0] d;
    out_t        res;
    if (start) clear_tracking();
    if (msg_bytes < SEEN_MAX) msg_bytes++;

    if (blank_pos >= 3'd4) begin
      if (body_count < LEN_MAX) body_count++;
    end else if (c == (blank_pos[0] ? CHAR_LF : CHAR_CR)) begin
      blank_pos++;
    end else begin
      blank_pos = (c == CHAR_CR) ? 3'd1 : 3'd0;
    end

    if (len_phase == PH_SEARCH) begin
      kp = (key_pos >= KEY_LEN) ? 5'd0 : key_pos;
      if (c == KEY_TEXT[8*(15-kp) +: 8]) kp++;
      else kp = (c == KEY_TEXT[127:120]) ? 5'd1 : 5'd0;
      key_pos = kp;
      if (kp == KEY_LEN) begin
        len_phase     = PH_VALUE;
        len_value     = '0;
        digit_seen    = 1'b0;
        digits_closed = 1'b0;
      end
    end else if (len_phase == PH_VALUE) begin
      if (history[0] == CHAR_CR && c == CHAR_LF) begin
        len_phase = digit_seen ? PH_VALID : PH_ERROR;
      end else if (!digits_closed) begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          d = {56'h0, c - CHAR_ZERO};
          len_value  = (len_value > (LEN_MAX - d) / 10) ? LEN_MAX : len_value * 10 + d;
          digit_seen = 1'b1;
        end else if (digit_seen || (c != CHAR_SPACE && c != CHAR_TAB)) begin
          digits_closed = 1'b1;
        end
      end
    end

    if (len_phase == PH_VALID && blank_pos >= 3'd4 && body_count >= len_value)
      rule = RULE_LENGTH;
    else if (msg_bytes > 4 && tail_match(BLANK_TAIL, 4, c))
      rule = RULE_BLANK;
    else if (msg_bytes > 7 && tail_match(LOWER_TAIL, 7, c))
      rule = RULE_LOWER;
    else if (msg_bytes > 9 && tail_match(UPPER_TAIL, 9, c))
      rule = RULE_UPPER;
    else
      rule = RULE_NONE;

    for (int i = 7; i > 0; i--) history[i] = history[i-1];
    history[0] = c;

    res.complete     = (rule != RULE_NONE);
    res.end_rule     = rule;
    res.length_error = (len_phase == PH_ERROR);
    res.header_done  = (blank_pos >= 3'd4);
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    out_t got_pred;
    if (rst) begin
      clear_tracking();
      expected_ends.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_ends.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: complete=%0d rule=%0d len_err=%0d hdr=%0d",
                     out_item.complete, out_item.end_rule, out_item.length_error,
                     out_item.header_done);
        end else begin
          want = expected_ends.pop_front();
          if (want !== out_item) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected complete=%0d rule=%0d len_err=%0d hdr=%0d, got complete=%0d rule=%0d len_err=%0d hdr=%0d",
                       want.complete, want.end_rule, want.length_error, want.header_done,
                       out_item.complete, out_item.end_rule, out_item.length_error,
                       out_item.header_done);
          end
        end
      end
      if (in_valid && in_ready) begin
        got_pred = next_end_result(in_item.data_byte, in_item.message_start);
        expected_ends.push_back(got_pred);
      end
    end
    mismatches <= fail_count;
    pending    <= expected_ends.size();
  end

endmodule

// ===== dv/http_message_end_detector_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the end detector testbench: builds HTTP-like byte streams, drives
// them with random idling and gives the verdict.
// Depends on hmed_pkg, http_message_end_detector_core and message_end_check.
module http_message_end_detector_core_tb;
  import hmed_pkg::*;

  localparam int TARGET_BYTES = 850;
  localparam int CYCLE_LIMIT  = 200000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_t        in_item   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_item;
  int         mismatches;
  int         pending;
  int         cycle_count   = 0;
  int         sent_bytes    = 0;
  int         send_idle_pct = 24;
  int         recv_idle_pct = 85;
  logic [7:0] msg_q [$];

  http_message_end_detector_core dut (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item
  );

  message_end_check end_check (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .mismatches, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic start);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: c, message_start: start};
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
  endtask

  // hold off until every request has its result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  task automatic push_crlf();
    msg_q.push_back(CHAR_CR);
    msg_q.push_back(CHAR_LF);
  endtask

  task automatic push_noise(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(7);
      if (r == 0) msg_q.push_back(CHAR_CR);
      else if (r == 1) msg_q.push_back(CHAR_LF);
      else msg_q.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic push_length_line(output int body_len);
    int pick;
    body_len = $urandom_range(6);
    if ($urandom_range(9) == 0) push_text("Content-Lenth: ");
    else push_text("Content-Length: ");
    repeat ($urandom_range(2)) msg_q.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
    pick = $urandom_range(9);
    case (pick)
      0: ;
      1: push_text("99999999999");
      2: push_text("4294967295");
      3: begin
        push_text($sformatf("%0d", body_len));
        push_text("x9");
      end
      4: begin
        push_text("-");
        push_text($sformatf("%0d", body_len));
      end
      default: push_text($sformatf("%0d", body_len));
    endcase
    push_crlf();
  endtask

  task automatic build_message();
    int kind;
    int body_len;
    int extra;
    int keep;
    msg_q.delete();
    kind = $urandom_range(9);
    body_len = $urandom_range(6);
    if (kind == 0) begin
      push_noise($urandom_range(1, 20));
    end else begin
      if ($urandom_range(3) == 0) push_noise($urandom_range(1, 3));
      push_text("GET / HTTP/1.1");
      push_crlf();
      if ($urandom_range(1)) begin
        push_text("Host: h");
        push_crlf();
      end
      if (kind <= 7) push_length_line(body_len);
      if ($urandom_range(7) == 0) push_length_line(extra);
      push_crlf();
      if ($urandom_range(5) == 0) push_length_line(extra);
      push_noise(body_len + $urandom_range(1));
      case ($urandom_range(5))
        0: push_text("</html>");
        1: begin
          push_text("</HTML>");
          push_crlf();
        end
        2: begin
          push_crlf();
          push_crlf();
        end
        default: ;
      endcase
    end
    // cut short so the next start lands mid-stream
    if ($urandom_range(9) == 0) begin
      keep = $urandom_range(1, msg_q.size());
      msg_q = msg_q[0:keep-1];
    end
  endtask

  task automatic send_queue(input logic first_start);
    foreach (msg_q[i])
      send_byte(msg_q[i], (i == 0) ? first_start : ($urandom_range(199) == 0));
  endtask

  initial begin
    int phase_end;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    msg_q.delete();
    msg_q.push_back(8'hFF);
    msg_q.push_back(8'h00);
    push_crlf();
    push_crlf();
    send_queue(1'b1);
    msg_q.delete();
    push_crlf();
    push_crlf();
    send_queue(1'b1);
    msg_q.delete();
    push_text("a</html>");
    send_queue(1'b1);
    msg_q.delete();
    push_text("x</HTML>");
    push_crlf();
    send_queue(1'b1);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 85 : 0;
      recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 24 : 0;
      phase_end = sent_bytes + TARGET_BYTES / 3;
      while (sent_bytes < phase_end) begin
        build_message();
        send_queue($urandom_range(9) != 0);
        if ($urandom_range(5) == 0) drain();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hmed_pkg.sv
hw/rtl/hmed_front.sv
hw/rtl/hmed_queue.sv
hw/rtl/hmed_back.sv
hw/rtl/http_message_end_detector_core.sv
dv/message_end_check.sv
dv/http_message_end_detector_core_tb.sv
